FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the RTL in this folder.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Check an implication property on every rising edge outside reset.
`define ASSERT_PROP(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that an expression is never true outside reset.
`define ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`else

`define ASSERT_PROP(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, expr, msg)

`endif

`endif

FILE: src/lbpt_pkg.sv
// ----------------------------------------------------------------------------
// lbpt_pkg
// Types and constants shared by the lane bit-plane transposer.
// ----------------------------------------------------------------------------
`default_nettype none

package lbpt_pkg;

   localparam int NUM_PLANES = 8;
   localparam int NUM_LANES  = 64;
   localparam int LANE_W     = 6;
   localparam int BIT_W      = 3;
   localparam int WORD_W     = 64;

   localparam logic [LANE_W-1:0] LAST_LANE = LANE_W'(NUM_LANES - 1);
   localparam logic [BIT_W-1:0]  TOP_BIT   = BIT_W'(NUM_PLANES - 1);
   localparam logic [BIT_W-1:0]  LOW_BIT   = '0;

   typedef struct packed {
      logic [7:0] lane_byte;
      logic       frame_end;
   } req_type;

   typedef struct packed {
      logic [WORD_W-1:0] plane_word;
      logic [BIT_W-1:0]  bit_number;
      logic              slot_last;
      logic              frame_last;
   } rsp_type;

   typedef logic [NUM_PLANES-1:0][WORD_W-1:0] plane_set_type;

endpackage

`default_nettype wire

FILE: src/lbpt_fill.sv
// ----------------------------------------------------------------------------
// lbpt_fill
// Lane counter and plane store; scatters each lane byte into eight planes.
// ----------------------------------------------------------------------------
`default_nettype none

module lbpt_fill
   import lbpt_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          in_accept,
   input  wire req_type       in_data,
   output      logic          slot_done,
   output      plane_set_type slot_planes
);

   logic [LANE_W-1:0] lane_ff;
   logic [LANE_W-1:0] lane_in;
   plane_set_type     plane_ff;
   logic [LANE_W-1:0] bit_pos;

   // lane k*8+j lands at byte j, bit k
   assign bit_pos = {lane_ff[2:0], lane_ff[5:3]};

   always_comb begin
      slot_planes = plane_ff;
      for (int b = 0; b < NUM_PLANES; b++) begin
         slot_planes[b][bit_pos] = in_data.lane_byte[b];
      end
   end

   assign slot_done = (lane_ff == LAST_LANE);
   assign lane_in   = lane_ff + LANE_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         lane_ff <= '0;
      end else if (in_accept) begin
         lane_ff <= lane_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_accept) begin
         plane_ff <= slot_planes;
      end
   end

endmodule

`default_nettype wire

FILE: src/lane_bit_plane_transposer_unit.sv
// ----------------------------------------------------------------------------
// lane_bit_plane_transposer_unit
// Transposes 64 lane bytes per slot into eight 64-bit bit-plane words.
// ----------------------------------------------------------------------------
// Takes one lane byte per cycle. The 64th byte of a slot copies the finished
// planes into a drain buffer, which hands out eight plane items (bit 7 first)
// through a registered output, one per cycle unless rsp_stall holds it, while the next slot fills.
// Sustained rate is one byte per cycle; the 64th byte of a slot stalls only
// while the drain buffer still holds planes of the previous slot that have
// not yet moved into the output register.
`default_nettype none

`include "assert_macros.svh"

module lane_bit_plane_transposer_unit
   import lbpt_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output      logic    req_stall,
   input  wire req_type req_data,
   output      logic    rsp_valid,
   input  wire logic    rsp_stall,
   output      rsp_type rsp_data
);

   logic          in_accept;
   logic          slot_done;
   plane_set_type slot_planes;

   plane_set_type     drain_ff;
   logic              busy_ff;
   logic              busy_in;
   logic [BIT_W-1:0]  idx_ff;
   logic [BIT_W-1:0]  idx_in;
   logic              frame_ff;
   logic              capture;
   logic              out_load;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   rsp_type           rsp_ff;
   rsp_type           rsp_in;

   lbpt_fill u_fill (
      .clock       (clock),
      .reset       (reset),
      .in_accept   (in_accept),
      .in_data     (req_data),
      .slot_done   (slot_done),
      .slot_planes (slot_planes)
   );

   // hold the final byte of a slot until the drain buffer is free
   assign req_stall = slot_done & busy_ff;
   assign in_accept = req_valid & ~req_stall;
   assign capture   = in_accept & slot_done;
   assign out_load  = busy_ff & (~rsp_valid_ff | ~rsp_stall);

   always_comb begin
      rsp_in.plane_word = drain_ff[idx_ff];
      rsp_in.bit_number = idx_ff;
      rsp_in.slot_last  = (idx_ff == LOW_BIT);
      rsp_in.frame_last = (idx_ff == LOW_BIT) & frame_ff;
   end

   always_comb begin
      busy_in = busy_ff;
      idx_in  = idx_ff;
      if (capture) begin
         busy_in = 1'b1;
         idx_in  = TOP_BIT;
      end else if (out_load) begin
         idx_in = idx_ff - BIT_W'(1);
         if (idx_ff == LOW_BIT) begin
            busy_in = 1'b0;
         end
      end
   end

   always_comb begin
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff & rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         idx_ff       <= TOP_BIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (capture) begin
         drain_ff <= slot_planes;
         frame_ff <= req_data.frame_end;
      end
      if (out_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `ASSERT_NEVER(a_no_overwrite, clock, reset, capture && busy_ff,
      "slot captured while drain buffer busy")
   `ASSERT_PROP(a_capture_arms, clock, reset,
      capture |=> (busy_ff && idx_ff == TOP_BIT),
      "drain did not start at the top plane")
   `ASSERT_PROP(a_slot_last_bit, clock, reset,
      (rsp_valid_ff && rsp_ff.slot_last) |-> (rsp_ff.bit_number == LOW_BIT),
      "slot_last on a plane other than bit 0")
   `ASSERT_PROP(a_frame_in_slot, clock, reset,
      (rsp_valid_ff && rsp_ff.frame_last) |-> rsp_ff.slot_last,
      "frame_last without slot_last")

endmodule

`default_nettype wire
